@@ src/msis_pkg.sv @@
`timescale 1ns / 1ps
package msis_pkg;

    // item kinds, encoded as the action field
    typedef enum logic [1:0] {
        K_STORE   = 2'd0,
        K_EXEC    = 2'd1,
        K_RESTART = 2'd2,
        K_NOP     = 2'd3
    } t_kind;

    typedef struct packed {
        t_kind       kind;
        logic [15:0] addr;
        logic [15:0] data;
    } t_item;

    // queue head as the back end sees it
    typedef struct packed {
        logic  valid;
        t_item item;
    } t_q_head;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_F1, S_F2, S_EX, S_MD, S_L1, S_L2, S_ST2, S_SC, S_RESP
    } t_state;

    typedef enum logic [1:0] {
        MD_MULT, MD_MULTU, MD_DIV, MD_DIVU
    } t_md_op;

    typedef enum logic [2:0] {
        MS_IDLE, MS_MUL, MS_FIX, MS_DIV, MS_NEG
    } t_md_state;

    typedef struct packed {
        logic   start;
        t_md_op op;
    } t_md_req;

    typedef struct packed {
        logic        done;
        logic [31:0] hi;
        logic [31:0] lo;
    } t_md_rsp;

    // primary opcodes
    localparam logic [5:0] OP_SPECIAL = 6'd0;
    localparam logic [5:0] OP_BGEZAL  = 6'd1;
    localparam logic [5:0] OP_J       = 6'd2;
    localparam logic [5:0] OP_JAL     = 6'd3;
    localparam logic [5:0] OP_BEQ     = 6'd4;
    localparam logic [5:0] OP_BNE     = 6'd5;
    localparam logic [5:0] OP_ADDI    = 6'd8;
    localparam logic [5:0] OP_SLTI    = 6'd10;
    localparam logic [5:0] OP_SLTIU   = 6'd11;
    localparam logic [5:0] OP_ANDI    = 6'd12;
    localparam logic [5:0] OP_ORI     = 6'd13;
    localparam logic [5:0] OP_XORI    = 6'd14;
    localparam logic [5:0] OP_LUI     = 6'd15;
    localparam logic [5:0] OP_COP0    = 6'd16;
    localparam logic [5:0] OP_MUL     = 6'd28;
    localparam logic [5:0] OP_LHX     = 6'd32;
    localparam logic [5:0] OP_LH      = 6'd33;
    localparam logic [5:0] OP_LWX     = 6'd34;
    localparam logic [5:0] OP_LW      = 6'd35;
    localparam logic [5:0] OP_LHUX    = 6'd36;
    localparam logic [5:0] OP_LHU     = 6'd37;
    localparam logic [5:0] OP_SHX     = 6'd40;
    localparam logic [5:0] OP_SH      = 6'd41;
    localparam logic [5:0] OP_SWX     = 6'd42;
    localparam logic [5:0] OP_SW      = 6'd43;

    // function codes under OP_SPECIAL
    localparam logic [5:0] FN_SLL     = 6'd0;
    localparam logic [5:0] FN_SRL     = 6'd2;
    localparam logic [5:0] FN_SRA     = 6'd3;
    localparam logic [5:0] FN_SLLV    = 6'd4;
    localparam logic [5:0] FN_SRLV    = 6'd6;
    localparam logic [5:0] FN_SRAV    = 6'd7;
    localparam logic [5:0] FN_JR      = 6'd8;
    localparam logic [5:0] FN_JALR    = 6'd9;
    localparam logic [5:0] FN_SYSCALL = 6'd12;
    localparam logic [5:0] FN_MFHI    = 6'd16;
    localparam logic [5:0] FN_MTHI    = 6'd18;
    localparam logic [5:0] FN_MFLO    = 6'd17;
    localparam logic [5:0] FN_MTLO    = 6'd19;
    localparam logic [5:0] FN_MULT    = 6'd24;
    localparam logic [5:0] FN_MULTU   = 6'd25;
    localparam logic [5:0] FN_DIV     = 6'd26;
    localparam logic [5:0] FN_DIVU    = 6'd27;
    localparam logic [5:0] FN_ADD     = 6'd32;
    localparam logic [5:0] FN_SUB     = 6'd34;
    localparam logic [5:0] FN_AND     = 6'd36;
    localparam logic [5:0] FN_OR      = 6'd37;
    localparam logic [5:0] FN_XOR     = 6'd38;
    localparam logic [5:0] FN_NOR     = 6'd39;
    localparam logic [5:0] FN_SLT     = 6'd42;
    localparam logic [5:0] FN_SLTU    = 6'd43;

    // coprocessor selectors in the rs field
    localparam logic [4:0] COP_MF     = 5'd0;
    localparam logic [4:0] COP_MT     = 5'd4;
    localparam logic [4:0] COP_ERET   = 5'd16;

    // fixed register indexes
    localparam logic [4:0] EPC_IDX    = 5'd14;
    localparam logic [4:0] RA_IDX     = 5'd31;
    localparam logic [4:0] V0_IDX     = 5'd2;
    localparam logic [4:0] A0_IDX     = 5'd4;
    localparam logic [4:0] SP_IDX     = 5'd29;
    localparam logic [4:0] FP_IDX     = 5'd30;

    // config register indexes
    localparam logic CFG_CODE_START = 1'b0;
    localparam logic CFG_CODE_END   = 1'b1;

endpackage

@@ src/msis_if.sv @@
`timescale 1ns / 1ps
// input channel
interface msis_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  action;
    logic [15:0] mem_addr;
    logic [15:0] mem_data;
    modport source(output valid, action, mem_addr, mem_data, input ready);
    modport sink(input valid, action, mem_addr, mem_data, output ready);
endinterface

// result channel
interface msis_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] pc;
    logic        finished;
    logic        self_loop;
    logic        syscall_valid;
    logic [31:0] syscall_number;
    logic [31:0] syscall_arg;
    modport source(output valid, pc, finished, self_loop, syscall_valid, syscall_number,
                   syscall_arg, input ready);
    modport sink(input valid, pc, finished, self_loop, syscall_valid, syscall_number,
                 syscall_arg, output ready);
endinterface

@@ src/msis_front.sv @@
`timescale 1ns / 1ps
module msis_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    msis_in_if.sink         i_in,
    input  logic            i_hold,
    input  logic            i_pop,
    output msis_pkg::t_q_head o_head
);
    logic [1:0]       r_cnt;
    logic             r_wp;
    logic             r_rp;
    msis_pkg::t_item  r_q [2];
    msis_pkg::t_item  w_item;
    logic             w_push;
    logic             w_pop;

    // classify the action into an item kind
    always_comb begin
        w_item.addr = i_in.mem_addr;
        w_item.data = i_in.mem_data;
        case (msis_pkg::t_kind'(i_in.action))
            msis_pkg::K_STORE:   w_item.kind = msis_pkg::K_STORE;
            msis_pkg::K_EXEC:    w_item.kind = msis_pkg::K_EXEC;
            msis_pkg::K_RESTART: w_item.kind = msis_pkg::K_RESTART;
            default:             w_item.kind = msis_pkg::K_NOP;
        endcase
    end

    assign i_in.ready = (r_cnt != 2'd2) && !i_hold;
    assign w_push     = i_in.valid && i_in.ready;
    assign w_pop      = i_pop && (r_cnt != 2'd0);

    assign o_head.valid = (r_cnt != 2'd0);
    assign o_head.item  = r_q[r_rp];

    // two-entry queue
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= w_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
        end else begin
            if (w_push) begin
                r_wp <= ~r_wp;
            end
            if (w_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(w_push) - 2'(w_pop);
        end
    end
endmodule

@@ src/msis_muldiv.sv @@
`timescale 1ns / 1ps
module msis_muldiv (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  msis_pkg::t_md_req i_req,
    input  logic [31:0]       i_a,
    input  logic [31:0]       i_b,
    output msis_pkg::t_md_rsp o_rsp
);
    msis_pkg::t_md_state r_state, n_state;
    logic        r_sgn, n_sgn;
    logic        r_neg, n_neg;
    logic [31:0] r_a, n_a;
    logic [31:0] r_b, n_b;
    logic [31:0] r_m, n_m;
    logic [31:0] r_rem, n_rem;
    logic [63:0] r_q, n_q;
    logic [63:0] r_p, n_p;
    logic [5:0]  r_cnt, n_cnt;
    logic        r_done, n_done;
    logic [31:0] r_hi, n_hi;
    logic [31:0] r_lo, n_lo;
    logic        w_na, w_nb, w_sgn;
    logic [31:0] w_ma, w_mb;
    logic [32:0] w_t;
    logic        w_ge;
    logic [63:0] w_fix, w_qf;

    assign o_rsp.done = r_done;
    assign o_rsp.hi   = r_hi;
    assign o_rsp.lo   = r_lo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= msis_pkg::MS_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sgn <= n_sgn;
        r_neg <= n_neg;
        r_a   <= n_a;
        r_b   <= n_b;
        r_m   <= n_m;
        r_rem <= n_rem;
        r_q   <= n_q;
        r_p   <= n_p;
        r_cnt <= n_cnt;
        r_hi  <= n_hi;
        r_lo  <= n_lo;
    end

    always_comb begin
        n_state = r_state;
        n_sgn   = r_sgn;
        n_neg   = r_neg;
        n_a     = r_a;
        n_b     = r_b;
        n_m     = r_m;
        n_rem   = r_rem;
        n_q     = r_q;
        n_p     = r_p;
        n_cnt   = r_cnt;
        n_done  = 1'b0;
        n_hi    = r_hi;
        n_lo    = r_lo;
        w_sgn   = (i_req.op == msis_pkg::MD_DIV) || (i_req.op == msis_pkg::MD_MULT);
        w_na    = w_sgn && i_a[31];
        w_nb    = w_sgn && i_b[31];
        w_ma    = w_na ? (32'd0 - i_a) : i_a;
        w_mb    = w_nb ? (32'd0 - i_b) : i_b;
        // one restoring step: shift in the next dividend bit
        w_t     = {r_rem, r_q[63]};
        w_ge    = (w_t >= {1'b0, r_m});
        // signed product correction
        w_fix   = r_p - ((r_sgn && r_a[31]) ? {r_b, 32'd0} : 64'd0)
                      - ((r_sgn && r_b[31]) ? {r_a, 32'd0} : 64'd0);
        w_qf    = r_neg ? (64'd0 - r_q) : r_q;
        case (r_state)
            msis_pkg::MS_IDLE: begin
                if (i_req.start) begin
                    n_a   = i_a;
                    n_b   = i_b;
                    n_sgn = w_sgn;
                    if ((i_req.op == msis_pkg::MD_MULT) || (i_req.op == msis_pkg::MD_MULTU)) begin
                        n_state = msis_pkg::MS_MUL;
                    end else if (i_b == 32'd0) begin
                        n_q     = 64'd0;
                        n_neg   = 1'b0;
                        n_state = msis_pkg::MS_NEG;
                    end else begin
                        n_m     = w_mb;
                        n_q     = {w_ma, 32'd0};
                        n_rem   = 32'd0;
                        n_cnt   = 6'd0;
                        n_neg   = w_na ^ w_nb;
                        n_state = msis_pkg::MS_DIV;
                    end
                end
            end
            msis_pkg::MS_MUL: begin
                n_p     = r_a * r_b;
                n_state = msis_pkg::MS_FIX;
            end
            msis_pkg::MS_FIX: begin
                n_hi    = w_fix[63:32];
                n_lo    = w_fix[31:0];
                n_done  = 1'b1;
                n_state = msis_pkg::MS_IDLE;
            end
            msis_pkg::MS_DIV: begin
                n_rem = w_ge ? 32'(w_t - {1'b0, r_m}) : w_t[31:0];
                n_q   = {r_q[62:0], w_ge};
                n_cnt = r_cnt + 6'd1;
                if (r_cnt == 6'd63) begin
                    n_state = msis_pkg::MS_NEG;
                end
            end
            msis_pkg::MS_NEG: begin
                // quotient high word to LO, fraction to HI
                n_lo    = w_qf[63:32];
                n_hi    = w_qf[31:0];
                n_done  = 1'b1;
                n_state = msis_pkg::MS_IDLE;
            end
            default: begin
                n_state = msis_pkg::MS_IDLE;
            end
        endcase
    end
endmodule

@@ src/msis_back.sv @@
`timescale 1ns / 1ps
module msis_back #(
    parameter int ADDR_BITS    = 16,
    parameter int NUM_COP_REGS = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  msis_pkg::t_q_head i_head,
    output logic              o_pop,
    output logic              o_clearing,
    input  logic [15:0]       i_code_start,
    input  logic [15:0]       i_code_end,
    msis_out_if.source        o_out,
    output msis_pkg::t_md_req o_md_req,
    output logic [31:0]       o_md_a,
    output logic [31:0]       o_md_b,
    input  msis_pkg::t_md_rsp i_md_rsp
);
    localparam int          CW       = $clog2(NUM_COP_REGS);
    localparam logic [31:0] SP_RESET = 32'((64'd1 << ADDR_BITS) + 64'd1);
    localparam logic [ADDR_BITS-1:0] CLR_LAST = {ADDR_BITS{1'b1}};

    msis_pkg::t_state r_state, n_state;
    logic [ADDR_BITS-1:0] r_clr, n_clr;
    logic [31:0] r_pc, n_pc;
    logic [31:0] r_orig, n_orig;
    logic [31:0] r_ins, n_ins;
    logic [15:0] r_hi16, n_hi16;
    logic [31:0] r_ea, n_ea;
    logic [31:0] r_hi, n_hi;
    logic [31:0] r_lo, n_lo;
    logic        r_sl, n_sl;
    logic        r_fin, n_fin;
    logic        r_scv, n_scv;
    logic [31:0] r_scn, n_scn;
    logic [31:0] r_sca, n_sca;

    // halfword memory, single port
    logic [15:0]          r_hw_mem [2**ADDR_BITS];
    logic [15:0]          r_mrd;
    logic                 m_we;
    logic [ADDR_BITS-1:0] m_addr;
    logic [15:0]          m_wd;

    // register file: one write, two registered reads
    logic [31:0] r_gpr_mem [32];
    logic [31:0] r_gv;
    logic [31:0] r_ga, r_gb;
    logic        g_we;
    logic [4:0]  g_wa, g_ra0, g_ra1;
    logic [31:0] g_wd;

    // coprocessor registers
    logic [31:0] r_cop [NUM_COP_REGS];
    logic        c_we;
    logic [31:0] w_cop_rd, w_epc;
    logic        w_rd_ok;

    // output register
    logic        r_ov;
    logic [31:0] r_opc, r_oscn, r_osca;
    logic        r_ofin, r_osl, r_oscv;
    logic        w_load_out;

    // decode
    logic [5:0]  w_op, w_fn;
    logic [4:0]  w_rs, w_rt, w_rd, w_sa;
    logic [15:0] w_imm;
    logic [31:0] w_simm, w_zimm, w_ea, w_pc2, w_a, w_b, w_npc;
    logic [63:0] w_prod;
    logic [31:0] w_ins;

    assign o_clearing = (r_state == msis_pkg::S_CLEAR);

    // state and control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= msis_pkg::S_CLEAR;
            r_clr   <= '0;
            r_pc    <= 32'd0;
            r_hi    <= 32'd0;
            r_lo    <= 32'd0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            r_pc    <= n_pc;
            r_hi    <= n_hi;
            r_lo    <= n_lo;
        end
    end

    always_ff @(posedge i_clk) begin
        r_orig <= n_orig;
        r_ins  <= n_ins;
        r_hi16 <= n_hi16;
        r_ea   <= n_ea;
        r_sl   <= n_sl;
        r_fin  <= n_fin;
        r_scv  <= n_scv;
        r_scn  <= n_scn;
        r_sca  <= n_sca;
    end

    // memory port
    always_ff @(posedge i_clk) begin
        if (m_we) begin
            r_hw_mem[m_addr] <= m_wd;
        end
        r_mrd <= r_hw_mem[m_addr];
    end

    // register file storage and read ports; unwritten entries read as reset value
    always_ff @(posedge i_clk) begin
        if (g_we) begin
            r_gpr_mem[g_wa] <= g_wd;
        end
        r_ga <= r_gv[g_ra0] ? r_gpr_mem[g_ra0]
              : (((g_ra0 == msis_pkg::SP_IDX) || (g_ra0 == msis_pkg::FP_IDX)) ? SP_RESET : 32'd0);
        r_gb <= r_gv[g_ra1] ? r_gpr_mem[g_ra1]
              : (((g_ra1 == msis_pkg::SP_IDX) || (g_ra1 == msis_pkg::FP_IDX)) ? SP_RESET : 32'd0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gv <= 32'd0;
        end else if (g_we) begin
            r_gv[g_wa] <= 1'b1;
        end
    end

    // coprocessor registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_COP_REGS; i++) begin
                r_cop[i] <= 32'd0;
            end
        end else if (c_we) begin
            r_cop[w_rd[CW-1:0]] <= w_b;
        end
    end

    assign w_rd_ok  = (32'(w_rd) < NUM_COP_REGS);
    assign w_cop_rd = w_rd_ok ? r_cop[w_rd[CW-1:0]] : 32'd0;
    assign w_epc    = r_cop[msis_pkg::EPC_IDX[CW-1:0]];

    // output register
    assign o_out.valid          = r_ov;
    assign o_out.pc             = r_opc;
    assign o_out.finished       = r_ofin;
    assign o_out.self_loop      = r_osl;
    assign o_out.syscall_valid  = r_oscv;
    assign o_out.syscall_number = r_oscn;
    assign o_out.syscall_arg    = r_osca;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (w_load_out) begin
            r_ov <= 1'b1;
        end else if (o_out.ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            r_opc  <= r_pc;
            r_ofin <= r_fin;
            r_osl  <= r_sl;
            r_oscv <= r_scv;
            r_oscn <= r_scn;
            r_osca <= r_sca;
        end
    end

    // instruction fields
    assign w_ins  = {r_hi16, r_mrd};
    assign w_op   = r_ins[31:26];
    assign w_fn   = r_ins[5:0];
    assign w_rs   = r_ins[25:21];
    assign w_rt   = r_ins[20:16];
    assign w_rd   = r_ins[15:11];
    assign w_sa   = r_ins[10:6];
    assign w_imm  = r_ins[15:0];
    assign w_simm = {{16{w_imm[15]}}, w_imm};
    assign w_zimm = {16'd0, w_imm};
    assign w_a    = r_ga;
    assign w_b    = r_gb;
    assign w_ea   = w_a + w_simm;
    assign w_pc2  = r_orig + 32'd2;
    assign w_prod = w_a * w_b;
    assign o_md_a = w_a;
    assign o_md_b = w_b;

    // next state and datapath control
    always_comb begin
        n_state   = r_state;
        n_clr     = r_clr;
        n_pc      = r_pc;
        n_orig    = r_orig;
        n_ins     = r_ins;
        n_hi16    = r_hi16;
        n_ea      = r_ea;
        n_hi      = r_hi;
        n_lo      = r_lo;
        n_sl      = r_sl;
        n_fin     = r_fin;
        n_scv     = r_scv;
        n_scn     = r_scn;
        n_sca     = r_sca;
        m_we      = 1'b0;
        m_addr    = ADDR_BITS'(r_pc);
        m_wd      = 16'd0;
        g_we      = 1'b0;
        g_wa      = w_rd;
        g_wd      = 32'd0;
        g_ra0     = w_ins[25:21];
        g_ra1     = w_ins[20:16];
        c_we      = 1'b0;
        o_pop     = 1'b0;
        o_md_req.start = 1'b0;
        o_md_req.op    = msis_pkg::MD_MULT;
        w_load_out = 1'b0;
        w_npc     = w_pc2;
        case (r_state)
            msis_pkg::S_CLEAR: begin
                m_we   = 1'b1;
                m_addr = r_clr;
                n_clr  = r_clr + ADDR_BITS'(1);
                if (r_clr == CLR_LAST) begin
                    n_state = msis_pkg::S_IDLE;
                end
            end
            msis_pkg::S_IDLE: begin
                n_fin = 1'b0;
                n_sl  = 1'b0;
                n_scv = 1'b0;
                n_scn = 32'd0;
                n_sca = 32'd0;
                if (i_head.valid) begin
                    o_pop   = 1'b1;
                    n_state = msis_pkg::S_RESP;
                    case (i_head.item.kind)
                        msis_pkg::K_STORE: begin
                            m_we   = 1'b1;
                            m_addr = ADDR_BITS'(i_head.item.addr);
                            m_wd   = i_head.item.data;
                        end
                        msis_pkg::K_RESTART: begin
                            n_pc = {16'd0, i_code_start};
                        end
                        msis_pkg::K_EXEC: begin
                            if (r_pc > {16'd0, i_code_end}) begin
                                n_fin = 1'b1;
                            end else begin
                                // read the high halfword
                                n_orig  = r_pc;
                                n_state = msis_pkg::S_F1;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            msis_pkg::S_F1: begin
                n_hi16  = r_mrd;
                m_addr  = ADDR_BITS'(r_orig + 32'd1);
                n_state = msis_pkg::S_F2;
            end
            msis_pkg::S_F2: begin
                // instruction complete; read rs and rt
                n_ins   = w_ins;
                n_state = msis_pkg::S_EX;
            end
            msis_pkg::S_EX: begin
                n_state = msis_pkg::S_RESP;
                g_wa    = w_rd;
                case (w_op)
                    msis_pkg::OP_SPECIAL: begin
                        g_we = 1'b1;
                        case (w_fn)
                            msis_pkg::FN_ADD:  g_wd = w_a + w_b;
                            msis_pkg::FN_SUB:  g_wd = w_a - w_b;
                            msis_pkg::FN_SLT:  g_wd = {31'd0, $signed(w_a) < $signed(w_b)};
                            msis_pkg::FN_SLTU: g_wd = {31'd0, w_a < w_b};
                            msis_pkg::FN_AND:  g_wd = w_a & w_b;
                            msis_pkg::FN_OR:   g_wd = w_a | w_b;
                            msis_pkg::FN_XOR:  g_wd = w_a ^ w_b;
                            msis_pkg::FN_NOR:  g_wd = ~(w_a | w_b);
                            msis_pkg::FN_SLL:  g_wd = w_a << w_sa;
                            msis_pkg::FN_SLLV: g_wd = w_a << w_b[4:0];
                            msis_pkg::FN_SRL:  g_wd = w_a >> w_sa;
                            msis_pkg::FN_SRLV: g_wd = w_a >> w_b[4:0];
                            msis_pkg::FN_SRA:  g_wd = 32'($signed(w_a) >>> w_sa);
                            msis_pkg::FN_SRAV: g_wd = 32'($signed(w_a) >>> w_b[4:0]);
                            msis_pkg::FN_MFHI: g_wd = r_hi;
                            msis_pkg::FN_MFLO: g_wd = r_lo;
                            msis_pkg::FN_JR: begin
                                g_we  = 1'b0;
                                w_npc = w_a;
                            end
                            msis_pkg::FN_JALR: begin
                                g_wd  = w_pc2;
                                w_npc = w_a;
                            end
                            msis_pkg::FN_MTHI: begin
                                g_we = 1'b0;
                                n_hi = w_a;
                            end
                            msis_pkg::FN_MTLO: begin
                                g_we = 1'b0;
                                n_lo = w_a;
                            end
                            msis_pkg::FN_SYSCALL: begin
                                g_we    = 1'b0;
                                n_scv   = 1'b1;
                                g_ra0   = msis_pkg::V0_IDX;
                                g_ra1   = msis_pkg::A0_IDX;
                                n_state = msis_pkg::S_SC;
                            end
                            msis_pkg::FN_MULT, msis_pkg::FN_MULTU,
                            msis_pkg::FN_DIV, msis_pkg::FN_DIVU: begin
                                g_we           = 1'b0;
                                o_md_req.start = 1'b1;
                                o_md_req.op    = msis_pkg::t_md_op'(w_fn[1:0]);
                                n_state        = msis_pkg::S_MD;
                            end
                            default: g_we = 1'b0;
                        endcase
                    end
                    msis_pkg::OP_MUL: begin
                        g_we = 1'b1;
                        g_wd = w_prod[31:0];
                    end
                    msis_pkg::OP_COP0: begin
                        if (w_rs == msis_pkg::COP_MF) begin
                            g_we = 1'b1;
                            g_wa = w_rt;
                            g_wd = w_cop_rd;
                        end else if (w_rs == msis_pkg::COP_MT) begin
                            c_we = w_rd_ok;
                        end else if (w_rs == msis_pkg::COP_ERET) begin
                            w_npc = w_epc;
                        end
                    end
                    msis_pkg::OP_LUI: begin
                        g_we = 1'b1;
                        g_wa = w_rt;
                        g_wd = {w_imm, 16'd0};
                    end
                    msis_pkg::OP_ADDI: begin
                        g_we = 1'b1;
                        g_wa = w_rt;
                        g_wd = w_ea;
                    end
                    msis_pkg::OP_SLTI: begin
                        g_we = 1'b1;
                        g_wa = w_rt;
                        g_wd = {31'd0, $signed(w_a) < $signed(w_simm)};
                    end
                    msis_pkg::OP_SLTIU: begin
                        g_we = 1'b1;
                        g_wa = w_rt;
                        g_wd = {31'd0, w_a < w_zimm};
                    end
                    msis_pkg::OP_ANDI: begin
                        g_we = 1'b1;
                        g_wa = w_rt;
                        g_wd = w_a & w_zimm;
                    end
                    msis_pkg::OP_ORI: begin
                        g_we = 1'b1;
                        g_wa = w_rt;
                        g_wd = w_a | w_zimm;
                    end
                    msis_pkg::OP_XORI: begin
                        g_we = 1'b1;
                        g_wa = w_rt;
                        g_wd = w_a ^ w_zimm;
                    end
                    msis_pkg::OP_LW, msis_pkg::OP_LWX, msis_pkg::OP_LH,
                    msis_pkg::OP_LHX, msis_pkg::OP_LHU, msis_pkg::OP_LHUX: begin
                        n_ea    = w_ea;
                        m_addr  = ADDR_BITS'(w_ea);
                        n_state = msis_pkg::S_L1;
                    end
                    msis_pkg::OP_SW: begin
                        n_ea    = w_ea;
                        m_we    = 1'b1;
                        m_addr  = ADDR_BITS'(w_ea);
                        m_wd    = w_b[31:16];
                        n_state = msis_pkg::S_ST2;
                    end
                    msis_pkg::OP_SWX: begin
                        n_ea    = w_ea;
                        m_we    = 1'b1;
                        m_addr  = ADDR_BITS'(w_ea);
                        m_wd    = w_b[15:0];
                        n_state = msis_pkg::S_ST2;
                    end
                    msis_pkg::OP_SH: begin
                        m_we   = 1'b1;
                        m_addr = ADDR_BITS'(w_ea + 32'd1);
                        m_wd   = w_b[15:0];
                    end
                    msis_pkg::OP_SHX: begin
                        m_we   = 1'b1;
                        m_addr = ADDR_BITS'(w_ea);
                        m_wd   = {w_b[7:0], w_b[15:8]};
                    end
                    msis_pkg::OP_BEQ: begin
                        if (w_a == w_b) begin
                            w_npc = w_pc2 + {w_simm[30:0], 1'b0};
                        end
                    end
                    msis_pkg::OP_BNE: begin
                        if (w_a != w_b) begin
                            w_npc = w_pc2 + {w_simm[30:0], 1'b0};
                        end
                    end
                    msis_pkg::OP_BGEZAL: begin
                        if (!w_a[31]) begin
                            g_we  = 1'b1;
                            g_wa  = msis_pkg::RA_IDX;
                            g_wd  = w_pc2;
                            w_npc = w_pc2 + {w_simm[30:0], 1'b0};
                        end
                    end
                    msis_pkg::OP_J: begin
                        w_npc = {w_pc2[31:27], r_ins[25:0], 1'b0};
                    end
                    msis_pkg::OP_JAL: begin
                        g_we  = 1'b1;
                        g_wa  = msis_pkg::RA_IDX;
                        g_wd  = w_pc2;
                        w_npc = {w_pc2[31:27], r_ins[25:0], 1'b0};
                    end
                    default: begin
                    end
                endcase
                n_pc = w_npc;
                n_sl = (w_npc == r_orig);
            end
            msis_pkg::S_MD: begin
                if (i_md_rsp.done) begin
                    n_hi    = i_md_rsp.hi;
                    n_lo    = i_md_rsp.lo;
                    n_state = msis_pkg::S_RESP;
                end
            end
            msis_pkg::S_L1: begin
                n_hi16  = r_mrd;
                m_addr  = ADDR_BITS'(r_ea + 32'd1);
                n_state = msis_pkg::S_L2;
            end
            msis_pkg::S_L2: begin
                // r_hi16 = m[ea], r_mrd = m[ea+1]
                g_we = 1'b1;
                g_wa = w_rt;
                case (w_op)
                    msis_pkg::OP_LW:   g_wd = {r_hi16, r_mrd};
                    msis_pkg::OP_LWX:  g_wd = {r_mrd, r_hi16};
                    msis_pkg::OP_LH:   g_wd = {{16{r_mrd[15]}}, r_mrd};
                    msis_pkg::OP_LHX:  g_wd = {{16{r_hi16[15]}}, r_hi16};
                    msis_pkg::OP_LHU:  g_wd = {16'd0, r_mrd};
                    default:           g_wd = {16'd0, r_hi16};
                endcase
                n_state = msis_pkg::S_RESP;
            end
            msis_pkg::S_ST2: begin
                m_we    = 1'b1;
                m_addr  = ADDR_BITS'(r_ea + 32'd1);
                m_wd    = (w_op == msis_pkg::OP_SW) ? w_b[15:0] : w_b[31:16];
                n_state = msis_pkg::S_RESP;
            end
            msis_pkg::S_SC: begin
                n_scn   = r_ga;
                n_sca   = r_gb;
                n_state = msis_pkg::S_RESP;
            end
            msis_pkg::S_RESP: begin
                if (!r_ov || o_out.ready) begin
                    w_load_out = 1'b1;
                    n_state    = msis_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = msis_pkg::S_IDLE;
            end
        endcase
    end

    // checks
    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> (r_state == msis_pkg::S_IDLE) && i_head.valid)
        else $error("queue popped outside idle");
    a_fetch_nowrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == msis_pkg::S_F1) || (r_state == msis_pkg::S_F2)) |-> !m_we)
        else $error("memory written during fetch");
    a_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load_out |-> (!r_ov || o_out.ready))
        else $error("result overwritten");
    a_md_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == msis_pkg::S_MD) && !i_md_rsp.done) |=> (r_state == msis_pkg::S_MD))
        else $error("left mul/div wait early");
    a_clear_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == msis_pkg::S_CLEAR) |-> !o_pop)
        else $error("item taken during memory clear");
endmodule

@@ src/mips_subset_instruction_step_unit.sv @@
`timescale 1ns / 1ps
// Channel  | Dir | Handshake      | Payload
// i_in     | in  | valid/ready    | action, mem_addr, mem_data
// o_out    | out | valid/ready    | pc, finished, self_loop, syscall_valid/number/arg
// APB      | in  | psel/penable   | code_start @0x0, code_end @0x4
//
// Store, restart and finished items are handled in the back end; an executed
// instruction takes two halfword fetches on the single memory port, register
// read, execute, plus load/store/syscall steps; mult goes through the shared
// mul/div unit, div through its iterative divider (one quotient bit a cycle).
// After reset the halfword memory is cleared with no item accepted. A two-entry
// queue takes items while the back end works or a result waits on a stalled
// o_out.
module mips_subset_instruction_step_unit #(
    parameter int ADDR_BITS    = 16,
    parameter int NUM_COP_REGS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    msis_in_if.sink     i_in,
    msis_out_if.source  o_out,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    logic [15:0]       r_code_start;
    logic [15:0]       r_code_end;
    msis_pkg::t_q_head w_head;
    logic              w_pop;
    logic              w_clearing;
    msis_pkg::t_md_req w_md_req;
    msis_pkg::t_md_rsp w_md_rsp;
    logic [31:0]       w_md_a, w_md_b;

    // configuration registers
    assign pready = 1'b1;
    assign prdata = (paddr[2] == msis_pkg::CFG_CODE_END) ? {16'd0, r_code_end}
                                                        : {16'd0, r_code_start};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_code_start <= 16'd0;
            r_code_end   <= 16'd0;
        end else if (psel && penable && pwrite && pready) begin
            if (paddr[2] == msis_pkg::CFG_CODE_END) begin
                r_code_end <= pwdata[15:0];
            end else begin
                r_code_start <= pwdata[15:0];
            end
        end
    end

    msis_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_hold  (w_clearing),
        .i_pop   (w_pop),
        .o_head  (w_head)
    );

    msis_muldiv u_muldiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_md_req),
        .i_a     (w_md_a),
        .i_b     (w_md_b),
        .o_rsp   (w_md_rsp)
    );

    msis_back #(
        .ADDR_BITS    (ADDR_BITS),
        .NUM_COP_REGS (NUM_COP_REGS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head       (w_head),
        .o_pop        (w_pop),
        .o_clearing   (w_clearing),
        .i_code_start (r_code_start),
        .i_code_end   (r_code_end),
        .o_out        (o_out),
        .o_md_req     (w_md_req),
        .o_md_a       (w_md_a),
        .o_md_b       (w_md_b),
        .i_md_rsp     (w_md_rsp)
    );
endmodule
